[design/ascon128_aead_packet_engine_macros.svh]
// Assertion macros for the Ascon-128 packet engine
`ifndef ASCON128_AEAD_PACKET_ENGINE_MACROS_SVH
`define ASCON128_AEAD_PACKET_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASC_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ASC_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define ASC_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define ASC_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

[design/asc_pkg.sv]
// Shared types, codes and the Ascon round function
`timescale 1ns / 1ps
`default_nettype none
package asc_pkg;
  localparam logic [63:0] IV_WORD = 64'h80400c0600000000;
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [1:0] {OP_START = 2'd0, OP_MSG = 2'd1, OP_TAG_HI = 2'd2,
                            OP_TAG_LO = 2'd3} op_t;
  typedef enum logic [1:0] {KIND_MSG = 2'd0, KIND_TAG = 2'd1, KIND_VERDICT = 2'd2,
                            KIND_RSVD = 2'd3} kind_t;
  typedef enum logic [1:0] {REG_KEY_HI = 2'd0, REG_KEY_LO = 2'd1, REG_DEC = 2'd2,
                            REG_NONE = 2'd3} reg_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] data_word;
    logic        is_final;
    logic [2:0]  nbytes;
  } cmd_t;

  typedef logic [4:0][63:0] state_t;

  function automatic logic [63:0] ror(input logic [63:0] v, input int unsigned r);
    ror = (v >> r) | (v << (64 - r));
  endfunction

  function automatic state_t round_fn(input state_t s, input logic [3:0] j);
    logic [63:0] x0, x1, x2, x3, x4, a0, a1, a2, a3, a4;
    x0 = s[0]; x1 = s[1]; x2 = s[2]; x3 = s[3]; x4 = s[4];
    x2 = x2 ^ {56'd0, 4'd15 - j, j};
    x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
    a0 = ~x0 & x1; a1 = ~x1 & x2; a2 = ~x2 & x3; a3 = ~x3 & x4; a4 = ~x4 & x0;
    x0 = x0 ^ a1; x1 = x1 ^ a2; x2 = x2 ^ a3; x3 = x3 ^ a4; x4 = x4 ^ a0;
    x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
    round_fn[0] = x0 ^ ror(x0, 19) ^ ror(x0, 28);
    round_fn[1] = x1 ^ ror(x1, 61) ^ ror(x1, 39);
    round_fn[2] = x2 ^ ror(x2, 1) ^ ror(x2, 6);
    round_fn[3] = x3 ^ ror(x3, 10) ^ ror(x3, 17);
    round_fn[4] = x4 ^ ror(x4, 7) ^ ror(x4, 41);
  endfunction
endpackage
`default_nettype wire

[design/asc_front.sv]
// Input stage: takes transactions, clamps byte count, pushes commands into a queue
`timescale 1ns / 1ps
`default_nettype none
module asc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     in_op,
  input  wire logic [63:0]    in_data_word,
  input  wire logic           in_is_final,
  input  wire logic [3:0]     in_byte_count,
  output logic                q_valid,
  output asc_pkg::cmd_t       q_cmd,
  input  wire logic           q_pop
);
  import asc_pkg::*;
  cmd_t       mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       c;
  logic       push;

  always_comb begin
    c.op = op_t'(in_op);
    c.data_word = in_data_word;
    c.is_final = in_is_final;
    c.nbytes = (in_byte_count > 4'd7) ? 3'd7 : in_byte_count[2:0];
  end
  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

[design/asc_back.sv]
// Execution stage: sponge state, round sequencer, result emission
`timescale 1ns / 1ps
`default_nettype none
module asc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  asc_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  input  wire logic [63:0]    key_high,
  input  wire logic [63:0]    key_low,
  input  wire logic           decrypt_mode,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          out_kind,
  output logic [63:0]         out_result_word,
  output logic [3:0]          out_valid_bytes,
  output logic                out_auth_ok,
  output logic                out_last
);
  import asc_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_RUN, S_EMIT} st_t;
  typedef enum logic [1:0] {PH_IDLE, PH_OPEN, PH_TAG_HI, PH_TAG_LO} ph_t;
  // what follows the running permutation
  typedef enum logic [2:0] {N_INIT, N_AD1, N_AD2, N_MSG, N_FIN} nx_t;

  st_t         st_r, st_nxt;
  ph_t         ph_r, ph_nxt;
  nx_t         nx_r, nx_nxt;
  state_t      x_r, x_nxt;
  logic [3:0]  rnd_r, rnd_nxt;
  logic        mis_r, mis_nxt;
  logic [63:0] word_r, word_nxt;
  logic [63:0] ctr_r, ctr_nxt;   // packet counter, absorbed after the init rounds
  logic [3:0]  nb_r, nb_nxt;
  logic [1:0]  emit_r, emit_nxt; // result index being shown: 0 block, 1 tag hi, 2 tag lo
  logic        ntag_r, ntag_nxt; // emit tags after block
  logic        ok_r, ok_nxt;
  logic        verdict_r, verdict_nxt;
  state_t      rnd_out;
  logic [63:0] mask, pad, d;

  assign rnd_out = round_fn(x_r, rnd_r);
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign d = q_cmd.data_word;
  assign mask = (q_cmd.nbytes == 3'd0) ? 64'd0 : ~64'd0 << (7'd64 - 7'(q_cmd.nbytes) * 7'd8);
  assign pad = 64'h80 << (6'd56 - 6'(q_cmd.nbytes) * 6'd8);

  always_comb begin
    out_valid = (st_r == S_EMIT);
    out_kind = verdict_r ? KIND_VERDICT : (emit_r == 2'd0 ? KIND_MSG : KIND_TAG);
    out_result_word = verdict_r ? 64'd0 : (emit_r == 2'd0 ? word_r :
                      (emit_r == 2'd1 ? x_r[3] : x_r[4]));
    out_valid_bytes = verdict_r ? 4'd0 : (emit_r == 2'd0 ? nb_r : 4'd8);
    out_auth_ok = verdict_r && ok_r;
    out_last = verdict_r || !ntag_r || (emit_r == 2'd2);
  end

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; nx_nxt = nx_r; x_nxt = x_r; rnd_nxt = rnd_r;
    mis_nxt = mis_r; word_nxt = word_r; ctr_nxt = ctr_r; nb_nxt = nb_r;
    emit_nxt = emit_r; ntag_nxt = ntag_r; ok_nxt = ok_r; verdict_nxt = verdict_r;
    unique case (st_r)
      S_IDLE: if (q_valid) begin
        emit_nxt = 2'd0; ntag_nxt = 1'b0; verdict_nxt = 1'b0;
        unique case (q_cmd.op)
          OP_START: begin
            x_nxt = {~d, d, key_low, key_high, IV_WORD};
            ctr_nxt = d;
            rnd_nxt = 4'd0; nx_nxt = N_INIT; mis_nxt = 1'b0;
            st_nxt = S_RUN;
          end
          OP_MSG: if (ph_r == PH_OPEN) begin
            if (!q_cmd.is_final) begin
              word_nxt = d ^ x_r[0];
              x_nxt[0] = decrypt_mode ? d : d ^ x_r[0];
              nb_nxt = 4'd8;
              rnd_nxt = 4'd6; nx_nxt = N_MSG; st_nxt = S_RUN;
            end else begin
              if (decrypt_mode) begin
                word_nxt = (d ^ x_r[0]) & mask;
                x_nxt[0] = (d & mask) | ((x_r[0] ^ pad) & ~mask);
              end else begin
                word_nxt = x_r[0] ^ ((d & mask) | pad);
                x_nxt[0] = x_r[0] ^ ((d & mask) | pad);
              end
              x_nxt[1] = x_r[1] ^ key_high; x_nxt[2] = x_r[2] ^ key_low;
              nb_nxt = {1'b0, q_cmd.nbytes};
              rnd_nxt = 4'd0; nx_nxt = N_FIN; st_nxt = S_RUN;
            end
          end
          OP_TAG_HI: if (ph_r == PH_TAG_HI) begin
            mis_nxt = (d != x_r[3]); ph_nxt = PH_TAG_LO;
          end
          OP_TAG_LO: if (ph_r == PH_TAG_LO) begin
            ok_nxt = !(mis_r || (d != x_r[4]));
            verdict_nxt = 1'b1; ph_nxt = PH_IDLE; st_nxt = S_EMIT;
          end
          default: ;
        endcase
      end
      S_RUN: begin
        x_nxt = rnd_out;
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'd11) begin
          rnd_nxt = 4'd6;
          unique case (nx_r)
            N_INIT: begin
              x_nxt[3] = rnd_out[3] ^ key_high; x_nxt[4] = rnd_out[4] ^ key_low;
              x_nxt[0] = rnd_out[0] ^ ctr_r; nx_nxt = N_AD1;
            end
            N_AD1: begin
              x_nxt[0] = rnd_out[0] ^ 64'h8000000000000000; nx_nxt = N_AD2;
            end
            N_AD2: begin
              x_nxt[4] = rnd_out[4] ^ 64'd1; ph_nxt = PH_OPEN; st_nxt = S_IDLE;
            end
            N_MSG: st_nxt = S_EMIT;
            N_FIN: begin
              x_nxt[3] = rnd_out[3] ^ key_high; x_nxt[4] = rnd_out[4] ^ key_low;
              ntag_nxt = !decrypt_mode;
              ph_nxt = decrypt_mode ? PH_TAG_HI : PH_IDLE;
              if (decrypt_mode) mis_nxt = 1'b0;
              st_nxt = S_EMIT;
            end
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_EMIT: if (out_ready) begin
        if (out_last) st_nxt = S_IDLE;
        else emit_nxt = emit_r + 2'd1;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= PH_IDLE; nx_r <= N_INIT; rnd_r <= 4'd0;
      mis_r <= 1'b0; emit_r <= 2'd0; ntag_r <= 1'b0; verdict_r <= 1'b0; ok_r <= 1'b0;
      x_r <= '0; word_r <= '0; ctr_r <= '0; nb_r <= 4'd0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; nx_r <= nx_nxt; rnd_r <= rnd_nxt;
      mis_r <= mis_nxt; emit_r <= emit_nxt; ntag_r <= ntag_nxt; verdict_r <= verdict_nxt;
      ok_r <= ok_nxt; x_r <= x_nxt; word_r <= word_nxt; ctr_r <= ctr_nxt; nb_r <= nb_nxt;
    end
  end
endmodule
`default_nettype wire

[design/ascon128_aead_packet_engine.sv]
// Top level of the Ascon-128 packet engine: register file, front queue, back sequencer
//
//  channel | signals                                   | role
//  in_     | in_valid/in_ready, op,data,final,bytes    | command transactions
//  out_    | out_valid/out_ready, kind,word,bytes,ok,last | result transactions
//  cfg_    | APB psel/penable/pwrite/paddr/pwdata       | key and direction
//
// A transaction enters the 2-entry queue at its accept edge and waits there until the idle
// back sequencer dispatches it. Start: 12 init rounds, then 6 rounds on each of two associated
// data blocks. Message block: 6 rounds, 1 result. Final block: 12 rounds, 1 or 3 results.
// Tag high word: no result; tag low word: 1 verdict result. Ignored items: no result.
// out_ready low holds the result until it is taken; synchronous reset.
`timescale 1ns / 1ps
`default_nettype none
module ascon128_aead_packet_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [63:0] in_data_word,
  input  wire logic        in_is_final,
  input  wire logic [3:0]  in_byte_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [63:0]      out_result_word,
  output logic [3:0]       out_valid_bytes,
  output logic             out_auth_ok,
  output logic             out_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  import asc_pkg::*;
  `include "ascon128_aead_packet_engine_macros.svh"

  logic [63:0] key_hi_r, key_lo_r;
  logic        dec_r;
  logic        q_valid, q_pop;
  cmd_t        q_cmd;
  reg_t        sel;

  assign cfg_pready = 1'b1;
  assign sel = (cfg_paddr[2:0] != 3'd0) ? REG_NONE :
               (cfg_paddr[4:3] == 2'd0 ? REG_KEY_HI :
               (cfg_paddr[4:3] == 2'd1 ? REG_KEY_LO :
               (cfg_paddr[4:3] == 2'd2 ? REG_DEC : REG_NONE)));

  always_comb begin
    unique case (sel)
      REG_KEY_HI: cfg_prdata = key_hi_r;
      REG_KEY_LO: cfg_prdata = key_lo_r;
      REG_DEC:    cfg_prdata = {63'd0, dec_r};
      default:    cfg_prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0; key_lo_r <= '0; dec_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (sel)
        REG_KEY_HI: key_hi_r <= cfg_pwdata;
        REG_KEY_LO: key_lo_r <= cfg_pwdata;
        REG_DEC:    dec_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  asc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_data_word, .in_is_final,
    .in_byte_count, .q_valid, .q_cmd, .q_pop
  );

  asc_back u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop,
    .key_high(key_hi_r), .key_low(key_lo_r), .decrypt_mode(dec_r),
    .out_valid, .out_ready, .out_kind, .out_result_word,
    .out_valid_bytes, .out_auth_ok, .out_last
  );

  `ASC_ASSERT_IMPL(a_verdict_last, clk, rst_n, out_valid && out_kind == KIND_VERDICT,
    out_last, "verdict must be last")
  `ASC_ASSERT_IMPL(a_ok_only_verdict, clk, rst_n, out_valid && out_auth_ok,
    out_kind == KIND_VERDICT, "auth_ok outside verdict")
  `ASC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_kind), "result dropped while stalled")
endmodule
`default_nettype wire

[tb/ascon128_aead_packet_engine_test.sv]
// Self-checking testbench for the Ascon-128 packet engine
`timescale 1ns / 1ps
module ascon128_aead_packet_engine_test;
  import asc_pkg::*;

  // Packet phase tracked by the expected-result model
  typedef enum logic [1:0] {PH_IDLE, PH_OPEN, PH_AWAIT_HI, PH_AWAIT_LO} phase_t;

  typedef struct {
    kind_t       kind;
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        ok;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [1:0]  in_op = OP_START;
  logic [63:0] in_data_word = '0;
  logic        in_is_final = 1'b0;
  logic [3:0]  in_byte_count = '0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire  [1:0]  out_kind;
  wire  [63:0] out_result_word;
  wire  [3:0]  out_valid_bytes;
  wire         out_auth_ok;
  wire         out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  wire  [63:0] cfg_prdata;
  wire         cfg_pready;

  ascon128_aead_packet_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_data_word(in_data_word), .in_is_final(in_is_final), .in_byte_count(in_byte_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_result_word(out_result_word), .out_valid_bytes(out_valid_bytes),
    .out_auth_ok(out_auth_ok), .out_last(out_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Model copy of the key, direction and sponge
  logic [63:0] key_hi_m, key_lo_m;
  logic        decrypt_m;
  logic [63:0] sponge [5];
  phase_t      phase_m;
  logic        tag_bad_m;

  result_t     results_due [$];
  int          fail_cnt;
  int          items_sent;
  int          send_gap_pct;
  int          recv_gap_pct;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int r);
    return (v >> r) | (v << (64 - r));
  endfunction

  // One Ascon round on the model sponge; round constant from index j
  task automatic sponge_round(input int j);
    logic [63:0] s0, s1, s2, s3, s4, t0, t1, t2, t3, t4;
    s0 = sponge[0]; s1 = sponge[1]; s2 = sponge[2]; s3 = sponge[3]; s4 = sponge[4];
    s2 ^= 64'((15 - j) * 16 + j);
    s0 ^= s4; s4 ^= s3; s2 ^= s1;
    t0 = ~s0 & s1; t1 = ~s1 & s2; t2 = ~s2 & s3; t3 = ~s3 & s4; t4 = ~s4 & s0;
    s0 ^= t1; s1 ^= t2; s2 ^= t3; s3 ^= t4; s4 ^= t0;
    s1 ^= s0; s0 ^= s4; s3 ^= s2; s2 = ~s2;
    sponge[0] = s0 ^ rotr(s0, 19) ^ rotr(s0, 28);
    sponge[1] = s1 ^ rotr(s1, 61) ^ rotr(s1, 39);
    sponge[2] = s2 ^ rotr(s2, 1) ^ rotr(s2, 6);
    sponge[3] = s3 ^ rotr(s3, 10) ^ rotr(s3, 17);
    sponge[4] = s4 ^ rotr(s4, 7) ^ rotr(s4, 41);
  endtask

  task automatic permute_sponge(input int nr);
    for (int i = 0; i < nr; i++) sponge_round(12 - nr + i);
  endtask

  task automatic push_result(input kind_t k, input logic [63:0] w, input logic [3:0] nb,
                             input logic ok, input logic last);
    result_t r;
    r.kind = k; r.word = w; r.nbytes = nb; r.ok = ok; r.last = last;
    results_due.insert(results_due.size(), r);
  endtask

  // Advance the model by one accepted command transaction
  task automatic predict_cipher(input op_t op, input logic [63:0] d, input logic fin,
                                input logic [3:0] bc);
    logic [63:0] r, mask, pad;
    int          n;
    case (op)
      OP_START: begin
        sponge[0] = IV_WORD; sponge[1] = key_hi_m; sponge[2] = key_lo_m;
        sponge[3] = d; sponge[4] = ~d;
        permute_sponge(12);
        sponge[3] ^= key_hi_m; sponge[4] ^= key_lo_m;
        sponge[0] ^= d;           // counter as one full AD block
        permute_sponge(6);
        sponge[0] ^= 64'h80 << 56; // AD padding block
        permute_sponge(6);
        sponge[4] ^= 64'd1;       // domain separation
        tag_bad_m = 1'b0;
        phase_m = PH_OPEN;
      end
      OP_MSG: begin
        if (phase_m == PH_OPEN) begin
          if (!fin) begin
            if (decrypt_m) begin
              r = d ^ sponge[0]; sponge[0] = d;
            end else begin
              sponge[0] ^= d; r = sponge[0];
            end
            permute_sponge(6);
            push_result(KIND_MSG, r, 4'd8, 1'b0, 1'b1);
          end else begin
            n = (bc > 7) ? 7 : int'(bc);
            mask = (n == 0) ? 64'd0 : ({64{1'b1}} << (64 - 8 * n));
            pad = 64'h80 << (56 - 8 * n);
            if (decrypt_m) begin
              r = (d ^ sponge[0]) & mask;
              sponge[0] = (d & mask) | ((sponge[0] ^ pad) & ~mask);
            end else begin
              sponge[0] ^= (d & mask) | pad;
              r = sponge[0];
            end
            sponge[1] ^= key_hi_m; sponge[2] ^= key_lo_m;
            permute_sponge(12);
            sponge[3] ^= key_hi_m; sponge[4] ^= key_lo_m;
            if (decrypt_m) begin
              push_result(KIND_MSG, r, 4'(n), 1'b0, 1'b1);
              tag_bad_m = 1'b0;
              phase_m = PH_AWAIT_HI;
            end else begin
              push_result(KIND_MSG, r, 4'(n), 1'b0, 1'b0);
              push_result(KIND_TAG, sponge[3], 4'd8, 1'b0, 1'b0);
              push_result(KIND_TAG, sponge[4], 4'd8, 1'b0, 1'b1);
              phase_m = PH_IDLE;
            end
          end
        end
      end
      OP_TAG_HI: begin
        if (phase_m == PH_AWAIT_HI) begin
          tag_bad_m = (d != sponge[3]);
          phase_m = PH_AWAIT_LO;
        end
      end
      default: begin
        if (phase_m == PH_AWAIT_LO) begin
          if (d != sponge[4]) tag_bad_m = 1'b1;
          push_result(KIND_VERDICT, 64'd0, 4'd0, !tag_bad_m, 1'b1);
          phase_m = PH_IDLE;
        end
      end
    endcase
  endtask

  // Called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_cmd(input op_t op, input logic [63:0] d, input logic fin,
                          input logic [3:0] bc);
    int   gap;
    logic rdy;
    gap = ($urandom_range(99) < send_gap_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_data_word <= d;
    in_is_final <= fin;
    in_byte_count <= bc;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    predict_cipher(op, d, fin, bc);
    items_sent++;
  endtask

  // Drop valid, then wait for every expected result plus engine settle time
  task automatic drain_engine();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input reg_t idx, input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_KEY_HI: key_hi_m = value;
      REG_KEY_LO: key_lo_m = value;
      REG_DEC:    decrypt_m = value[0];
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [63:0] khi, input logic [63:0] klo,
                            input logic dec);
    write_reg(REG_KEY_HI, khi);
    write_reg(REG_KEY_LO, klo);
    write_reg(REG_DEC, {63'd0, dec});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Encrypt: extreme keys/counters, final lengths 0 and 7 (incl. clamped counts), stray commands
  task automatic test_encrypt_directed();
    load_setup('0, '0, 1'b0);
    send_cmd(OP_MSG, '1, 1'b0, 4'd8);          // no packet open: dropped
    send_cmd(OP_TAG_LO, '1, 1'b0, 4'd0);       // tag in wrong phase: dropped
    send_cmd(OP_START, '0, 1'b0, 4'd0);
    send_cmd(OP_MSG, '1, 1'b0, 4'd15);         // non-final ignores byte count
    send_cmd(OP_MSG, '0, 1'b1, 4'd0);          // empty final block
    drain_engine();
    load_setup('1, '1, 1'b0);
    send_cmd(OP_START, '1, 1'b0, 4'd0);
    send_cmd(OP_START, 64'h0123_4567_89ab_cdef, 1'b0, 4'd0);  // abandon open packet
    send_cmd(OP_TAG_HI, '1, 1'b0, 4'd0);       // dropped while open
    send_cmd(OP_MSG, '1, 1'b1, 4'd7);
    send_cmd(OP_START, 64'd5, 1'b0, 4'd0);
    send_cmd(OP_MSG, 64'hdead_beef_0000_ffff, 1'b1, 4'd15);   // over-long count clamps
    send_cmd(OP_START, 64'd6, 1'b0, 4'd0);
    send_cmd(OP_MSG, 64'h8000_0000_0000_0001, 1'b1, 4'd8);
    drain_engine();
  endtask

  // Decrypt: good tag, bad high word, bad low word
  task automatic test_decrypt_directed();
    load_setup(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, 1'b1);
    send_cmd(OP_START, 64'd1, 1'b0, 4'd0);
    send_cmd(OP_MSG, 64'h1122_3344_5566_7788, 1'b0, 4'd8);
    send_cmd(OP_MSG, '1, 1'b1, 4'd3);
    send_cmd(OP_TAG_LO, sponge[4], 1'b0, 4'd0); // out of order: dropped
    send_cmd(OP_TAG_HI, sponge[3], 1'b0, 4'd0);
    send_cmd(OP_TAG_LO, sponge[4], 1'b0, 4'd0);
    send_cmd(OP_START, 64'd2, 1'b0, 4'd0);
    send_cmd(OP_MSG, '0, 1'b1, 4'd0);
    send_cmd(OP_TAG_HI, ~sponge[3], 1'b0, 4'd0);
    send_cmd(OP_TAG_LO, sponge[4], 1'b0, 4'd0);
    send_cmd(OP_START, 64'd3, 1'b0, 4'd0);
    send_cmd(OP_MSG, '1, 1'b1, 4'd15);
    send_cmd(OP_TAG_HI, sponge[3], 1'b0, 4'd0);
    send_cmd(OP_TAG_LO, sponge[4] ^ 64'd1, 1'b0, 4'd0);
    drain_engine();
  endtask

  // Mostly well-formed packets with random content, some noise and cut-off packets
  task automatic random_packet();
    int nblk;
    if ($urandom_range(99) < 10) begin
      send_cmd(op_t'($urandom_range(3)), rand64(), 1'($urandom), 4'($urandom));
    end else begin
      send_cmd(OP_START, rand64(), 1'($urandom), 4'($urandom));
      nblk = $urandom_range(0, 3);
      for (int i = 0; i < nblk; i++) send_cmd(OP_MSG, rand64(), 1'b0, 4'($urandom));
      if ($urandom_range(99) < 8) return;   // packet cut off, next start abandons it
      send_cmd(OP_MSG, rand64(), 1'b1,
               ($urandom_range(99) < 85) ? 4'($urandom_range(7)) : 4'($urandom));
      if (decrypt_m) begin
        send_cmd(OP_TAG_HI, ($urandom_range(99) < 80) ? sponge[3] : rand64(), 1'b0, 4'd0);
        send_cmd(OP_TAG_LO, ($urandom_range(99) < 80) ? sponge[4] : rand64(), 1'b0, 4'd0);
      end
    end
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_items);
    int target;
    send_gap_pct = s_pct;
    recv_gap_pct = r_pct;
    for (int half = 0; half < 2; half++) begin
      load_setup(rand64(), rand64(), 1'(half));
      target = items_sent + n_items / 2;
      while (items_sent < target) random_packet();
      drain_engine();
    end
  endtask

  // Sender holds off mid-stream until the engine has delivered everything
  task automatic test_sender_holdoff();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    load_setup(rand64(), '1, 1'b0);
    random_packet();
    random_packet();
    drain_engine();
    random_packet();
    drain_engine();
  endtask

  // Result receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // Outputs are stable between rising edges, so sample on the falling edge
  always @(negedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result kind=%0d word=%h", $time, out_kind,
                 out_result_word);
        fail_cnt++;
      end else begin
        want = results_due.pop_front();
        if (out_kind !== want.kind) begin
          $display("%0t: kind exp %0d got %0d", $time, want.kind, out_kind);
          fail_cnt++;
        end
        if (out_result_word !== want.word) begin
          $display("%0t: result_word exp %h got %h", $time, want.word, out_result_word);
          fail_cnt++;
        end
        if (out_valid_bytes !== want.nbytes) begin
          $display("%0t: valid_bytes exp %0d got %0d", $time, want.nbytes,
                   out_valid_bytes);
          fail_cnt++;
        end
        if (out_auth_ok !== want.ok) begin
          $display("%0t: auth_ok exp %0d got %0d", $time, want.ok, out_auth_ok);
          fail_cnt++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, out_last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    key_hi_m = '0; key_lo_m = '0; decrypt_m = 1'b0;
    foreach (sponge[i]) sponge[i] = '0;
    phase_m = PH_IDLE;
    tag_bad_m = 1'b0;
    fail_cnt = 0;
    items_sent = 0;
    send_gap_pct = 36;
    recv_gap_pct = 51;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encrypt_directed();
    test_decrypt_directed();
    test_random_traffic(36, 51, 60);
    test_random_traffic(51, 36, 60);
    test_random_traffic(0, 0, 60);
    test_sender_holdoff();
    drain_engine();
    if (fail_cnt == 0 && results_due.size() == 0) begin
      $display("ascon128_aead_packet_engine_test OK");
    end else begin
      $display("ascon128_aead_packet_engine_test NOT OK");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("ascon128_aead_packet_engine_test NOT OK");
    $finish;
  end
endmodule
